// ===== rtl/gsc_pkg.sv =====
// Package for the gearbox shift controller.
// Holds the operation codes, the register map and the gear table entry type.
// No dependencies.
package gsc_pkg;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_SHIFT_UP   = 3'd1,
      OP_SHIFT_DOWN = 3'd2,
      OP_SELECT     = 3'd3,
      OP_LOAD       = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      REG_AUTOMATIC_MODE = 3'd0,
      REG_GEAR_COUNT     = 3'd1,
      REG_SHIFT_TIME     = 3'd2,
      REG_REVERSE_RATIO  = 3'd3,
      REG_LAUNCH_RPM     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] ratio;
      logic [14:0]        rpm_low;
      logic [14:0]        rpm_high;
   } gear_entry_type;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 24;

   localparam logic [24:0]        TIMER_MAX          = 25'h1FF_FFFF;
   localparam logic [4:0]         GEAR_COUNT_RESET   = 5'd5;
   localparam logic [23:0]        SHIFT_TIME_RESET   = 24'd500000;
   localparam logic signed [15:0] REVERSE_RATIO_RESET = -16'sd4096;
   localparam logic [14:0]        LAUNCH_RPM_RESET   = 15'd2000;
   localparam logic signed [5:0]  GEAR_REVERSE       = -6'sd1;
   localparam logic signed [5:0]  GEAR_NEUTRAL       = 6'sd0;

endpackage

// ===== rtl/gearbox_shift_controller_core.sv =====
// Top level of the gearbox shift controller: stream ports, control registers,
// gear table and the single-pass shift logic.
// Depends on gsc_pkg.
//
//   Port group | Role               | Contents
//   req_*      | stream in, slave   | one command item per handshake
//   rsp_*      | stream out, master | one result item per command item
//   csr_*      | register port      | five control registers, pready always high
//
// An item moves through an input register, the decision stage that updates the
// gear state, and the result register, which drives rsp_tvalid.
// Without a stall one item is accepted per cycle; the gear table is read through
// one registered port at the next gear, so the ratio is formed one stage later.
// Synchronous active-high reset clears the gear state and the table valid bits.
// A stalled result holds the earlier stages and, once they are full, req_tready.
module gearbox_shift_controller_core #(
   parameter int MAX_GEARS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // elapsed_us[15:0], engine_rpm[31:16], gear_number[37:32],
   // entry_ratio[53:38], entry_rpm_low[68:54], entry_rpm_high[83:69], zero[87:84]
   input  logic [gsc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode[2:0]
   input  logic [gsc_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // effective_ratio[15:0], current_gear[21:16], shift_active[22],
   // command_taken[23]
   output logic [gsc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   import gsc_pkg::*;

   localparam int IDX_W = (MAX_GEARS > 1) ? $clog2(MAX_GEARS) : 1;
   localparam logic signed [7:0] MAX_S = 8'(MAX_GEARS);
   localparam logic [6:0] MAX_U = 7'(MAX_GEARS);

   // Control registers.
   logic               auto_mode_ff;
   logic [4:0]         gear_count_ff;
   logic [23:0]        shift_time_ff;
   logic signed [15:0] reverse_ratio_ff;
   logic [14:0]        launch_rpm_ff;

   // Gear state.
   logic signed [5:0]  gear_ff, gear_in;
   logic               flag_ff, flag_in;
   logic [24:0]        timer_ff, timer_in;
   gear_entry_type     entry_ff;

   // Gear table with one valid bit per entry.
   gear_entry_type     table_mem [MAX_GEARS];
   logic [MAX_GEARS-1:0] valid_ff;

   // Pipeline registers.
   logic               s0_valid_ff;
   logic [REQ_DATA_W-1:0] s0_data_ff;
   logic [REQ_USER_W-1:0] s0_user_ff;
   logic               p1_valid_ff;
   logic               p1_taken_ff;
   logic               out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   // Decoded input fields.
   opcode_type         op;
   logic [15:0]        elapsed;
   logic signed [15:0] rpm;
   logic signed [5:0]  num;
   gear_entry_type     load_entry;

   logic               out_load, p1_accept, compute, taken_in;
   logic [6:0]         acnt;
   logic signed [7:0]  acnt_s, gear_s, num_s, gear_in_s;
   logic signed [7:0]  num_idx_s, gear_in_idx_s;
   logic signed [16:0] rpm_s, high_s, low_s, launch_s;
   logic [25:0]        timer_sum;
   logic [24:0]        timer_sat;
   logic               wr_en, rd_ok;
   logic [IDX_W-1:0]   wr_idx, rd_idx;
   logic signed [15:0] ratio_now;
   logic               csr_write;
   reg_index_type      csr_reg;

   assign op         = opcode_type'(s0_user_ff);
   assign elapsed    = s0_data_ff[15:0];
   assign rpm        = s0_data_ff[31:16];
   assign num        = s0_data_ff[37:32];
   assign load_entry = '{ratio: s0_data_ff[53:38], rpm_low: s0_data_ff[68:54],
                         rpm_high: s0_data_ff[83:69]};

   // Handshake control.
   assign out_load   = !out_valid_ff || rsp_tready;
   assign p1_accept  = !p1_valid_ff || out_load;
   assign compute    = s0_valid_ff && p1_accept;
   assign req_tready = !s0_valid_ff || compute;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign acnt   = ({2'b00, gear_count_ff} > MAX_U) ? MAX_U : {2'b00, gear_count_ff};
   assign acnt_s = $signed({1'b0, acnt});
   assign gear_s = 8'(gear_ff);
   assign num_s  = 8'(num);

   assign rpm_s    = 17'(rpm);
   assign high_s   = $signed({2'b00, entry_ff.rpm_high});
   assign low_s    = $signed({2'b00, entry_ff.rpm_low});
   assign launch_s = $signed({2'b00, launch_rpm_ff});

   assign timer_sum = {1'b0, timer_ff} + {10'b0, elapsed};
   assign timer_sat = timer_sum[25] ? TIMER_MAX : timer_sum[24:0];

   always_comb begin
      gear_in  = gear_ff;
      flag_in  = flag_ff;
      timer_in = timer_ff;
      taken_in = 1'b0;
      wr_en    = 1'b0;
      unique case (op)
         OP_TICK: begin
            if (flag_ff) begin
               timer_in = timer_sat;
               if (timer_sat > {1'b0, shift_time_ff}) begin
                  flag_in = 1'b0;
               end
            end else if (auto_mode_ff) begin
               if (gear_s > 8'sd0) begin
                  if (rpm_s > high_s) begin
                     flag_in  = 1'b1;
                     timer_in = '0;
                     taken_in = 1'b1;
                     if (gear_s < acnt_s) begin
                        gear_in = 6'(gear_s + 8'sd1);
                     end
                  end else if (rpm_s < low_s && gear_s > 8'sd1) begin
                     flag_in  = 1'b1;
                     timer_in = '0;
                     taken_in = 1'b1;
                     gear_in  = 6'(gear_s - 8'sd1);
                  end
               end else if (gear_ff == GEAR_NEUTRAL) begin
                  if (rpm_s > launch_s) begin
                     flag_in  = 1'b1;
                     timer_in = '0;
                     taken_in = 1'b1;
                     if (gear_s < acnt_s) begin
                        gear_in = 6'(gear_s + 8'sd1);
                     end
                  end
               end
            end
         end
         OP_SHIFT_UP: begin
            if (!flag_ff) begin
               flag_in  = 1'b1;
               timer_in = '0;
               taken_in = 1'b1;
               if (gear_s < acnt_s) begin
                  gear_in = 6'(gear_s + 8'sd1);
               end
            end
         end
         OP_SHIFT_DOWN: begin
            if (!flag_ff) begin
               flag_in  = 1'b1;
               timer_in = '0;
               taken_in = 1'b1;
               if (gear_ff != GEAR_REVERSE) begin
                  gear_in = 6'(gear_s - 8'sd1);
               end
            end
         end
         OP_SELECT: begin
            if (!flag_ff && num_s >= -8'sd1 && num_s <= acnt_s) begin
               flag_in  = 1'b1;
               timer_in = '0;
               taken_in = 1'b1;
               gear_in  = num;
            end
         end
         OP_LOAD: begin
            if (num_s > 8'sd0 && num_s <= acnt_s) begin
               wr_en    = 1'b1;
               taken_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Table addressing: writes go to the loaded entry, the read follows the next gear.
   assign num_idx_s     = num_s - 8'sd1;
   assign wr_idx        = num_idx_s[IDX_W-1:0];
   assign gear_in_s     = compute ? 8'(gear_in) : gear_s;
   assign gear_in_idx_s = gear_in_s - 8'sd1;
   assign rd_idx        = gear_in_idx_s[IDX_W-1:0];
   assign rd_ok         = gear_in_s >= 8'sd1 && gear_in_s <= MAX_S;

   always_ff @(posedge clock) begin
      if (compute && wr_en) begin
         table_mem[wr_idx] <= load_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         entry_ff <= '0;
      end else begin
         if (compute && wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (compute && wr_en && rd_ok && wr_idx == rd_idx) begin
            entry_ff <= load_entry;
         end else if (rd_ok && valid_ff[rd_idx]) begin
            entry_ff <= table_mem[rd_idx];
         end else begin
            entry_ff <= '0;
         end
      end
   end

   // Gear state and pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff      <= GEAR_NEUTRAL;
         flag_ff      <= 1'b0;
         timer_ff     <= '0;
         s0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (compute) begin
            gear_ff  <= gear_in;
            flag_ff  <= flag_in;
            timer_ff <= timer_in;
         end
         if (req_tready) begin
            s0_valid_ff <= req_tvalid;
         end
         if (p1_accept) begin
            p1_valid_ff <= compute;
         end
         if (out_load) begin
            out_valid_ff <= p1_valid_ff;
         end
      end
   end

   always_comb begin
      ratio_now = '0;
      if (!flag_ff) begin
         if (gear_s > 8'sd0 && gear_s <= acnt_s) begin
            ratio_now = entry_ff.ratio;
         end else if (gear_ff == GEAR_REVERSE) begin
            ratio_now = reverse_ratio_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s0_data_ff <= req_tdata;
         s0_user_ff <= req_tuser;
      end
      if (compute) begin
         p1_taken_ff <= taken_in;
      end
      if (out_load && p1_valid_ff) begin
         out_data_ff <= {p1_taken_ff, flag_ff, gear_ff, ratio_now};
      end
   end

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_mode_ff     <= 1'b0;
         gear_count_ff    <= GEAR_COUNT_RESET;
         shift_time_ff    <= SHIFT_TIME_RESET;
         reverse_ratio_ff <= REVERSE_RATIO_RESET;
         launch_rpm_ff    <= LAUNCH_RPM_RESET;
      end else if (csr_write) begin
         unique case (csr_reg)
            REG_AUTOMATIC_MODE: auto_mode_ff     <= csr_pwdata[0];
            REG_GEAR_COUNT:     gear_count_ff    <= csr_pwdata[4:0];
            REG_SHIFT_TIME:     shift_time_ff    <= csr_pwdata[23:0];
            REG_REVERSE_RATIO:  reverse_ratio_ff <= csr_pwdata[15:0];
            REG_LAUNCH_RPM:     launch_rpm_ff    <= csr_pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_AUTOMATIC_MODE: csr_prdata = {31'b0, auto_mode_ff};
         REG_GEAR_COUNT:     csr_prdata = {27'b0, gear_count_ff};
         REG_SHIFT_TIME:     csr_prdata = {8'b0, shift_time_ff};
         REG_REVERSE_RATIO:  csr_prdata = 32'(reverse_ratio_ff);
         REG_LAUNCH_RPM:     csr_prdata = {17'b0, launch_rpm_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // A shift always starts with a cleared timer.
   a_shift_start_timer: assert property (@(posedge clock) disable iff (reset)
      $rose(flag_ff) |-> timer_ff == '0)
      else $error("shift started without clearing the timer");

   // The gear stays between reverse and the table depth.
   a_gear_range: assert property (@(posedge clock) disable iff (reset)
      gear_s >= -8'sd1 && gear_s <= MAX_S)
      else $error("gear out of range");

   // While the middle stage is held, the state that forms its ratio stays put.
   a_held_state: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && !out_load |=> $stable(gear_ff) && $stable(flag_ff)
         && $stable(entry_ff))
      else $error("gear state changed under a held item");

endmodule
